@@ rtl/core/pes_pkg.sv @@
// shared types, codes and constants of the periodic event scheduler
package pes_pkg;

    // default table size
    localparam int MAX_SOURCES_DEF = 64;

    // depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // input opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // saturation value of the next time
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // one input transfer
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] source_id;
        logic [15:0] period;
    } t_in;

    // one result transfer
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] event_id;
        logic [31:0] event_time;
        logic        saturated;
    } t_out;

    // classified command kinds
    typedef enum logic [1:0] {
        K_NOP,
        K_CLEAR,
        K_ADD,
        K_EMIT
    } t_kind;

    // command held in the queue
    typedef struct packed {
        t_kind       kind;
        logic [15:0] source_id;
        logic [15:0] period;
    } t_cmd;

    // one table entry as stored in memory
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] period;
        logic [31:0] next_time;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/core/pes_ram.sv @@
// generic single-write, single-read ram with registered read data
module pes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/pes_front.sv @@
// front end: accepts transfers, decodes the opcode, queues commands
module pes_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pes_pkg::t_in   i_data,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output pes_pkg::t_cmd  o_q_cmd
);

    localparam int QAW = (pes_pkg::Q_DEPTH > 1) ? $clog2(pes_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(pes_pkg::Q_DEPTH + 1);

    pes_pkg::t_cmd  r_q [pes_pkg::Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    pes_pkg::t_cmd  w_cmd;
    logic           w_push;

    // opcode decode
    always_comb begin
        w_cmd.source_id = i_data.source_id;
        w_cmd.period    = i_data.period;
        unique case (i_data.opcode)
            pes_pkg::OP_CLEAR: w_cmd.kind = pes_pkg::K_CLEAR;
            pes_pkg::OP_ADD:   w_cmd.kind = pes_pkg::K_ADD;
            pes_pkg::OP_EMIT:  w_cmd.kind = pes_pkg::K_EMIT;
            default:           w_cmd.kind = pes_pkg::K_NOP;
        endcase
    end

    assign busy   = (r_cnt == QCW'(pes_pkg::Q_DEPTH));
    assign w_push = start && !busy;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(pes_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == QAW'(pes_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];

    // queue checks
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_cnt != '0))
        else $error("pop from empty command queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(pes_pkg::Q_DEPTH))
        else $error("command queue overfilled");

endmodule

@@ rtl/core/pes_back.sv @@
// back end: executes commands against the source table and drives results
module pes_back #(
    parameter int MAX_SOURCES = pes_pkg::MAX_SOURCES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  pes_pkg::t_cmd i_q_cmd,
    output logic          o_strobe,
    output pes_pkg::t_out o_result
);

    localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CW = $clog2(MAX_SOURCES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_addr;
    logic            r_issue;
    logic            r_rd_valid;
    logic [AW-1:0]   r_rd_idx;
    logic            r_first;
    pes_pkg::t_entry r_best;
    logic [AW-1:0]   r_best_idx;
    logic            r_strobe;
    pes_pkg::t_out   r_result;

    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    pes_pkg::t_entry             w_wr_data;
    logic                        w_rd_en;
    logic [pes_pkg::ENTRY_W-1:0] w_rd_raw;
    pes_pkg::t_entry             w_rd;
    logic                        w_full;
    logic [CW-1:0]               w_last;
    logic                        w_take;
    logic [32:0]                 w_sum;
    logic [31:0]                 w_nt;
    logic                        w_quick;
    pes_pkg::t_out               w_quick_res;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_full  = (r_count == CW'(MAX_SOURCES));
    assign w_last  = r_count - CW'(1);
    assign w_rd    = pes_pkg::t_entry'(w_rd_raw);

    // candidate beats current best: earlier time, or same time and lower id
    assign w_take = r_first || (w_rd.next_time < r_best.next_time) ||
                    ((w_rd.next_time == r_best.next_time) && (w_rd.id < r_best.id));

    // advance with saturation
    assign w_sum = {1'b0, r_best.next_time} + {17'b0, r_best.period};
    assign w_nt  = w_sum[32] ? pes_pkg::TIME_MAX : w_sum[31:0];

    // commands that finish in their idle cycle and the result they give
    assign w_quick = !((i_q_cmd.kind == pes_pkg::K_EMIT) && (r_count != '0));

    always_comb begin
        w_quick_res = '0;
        if ((i_q_cmd.kind == pes_pkg::K_ADD) && w_full) begin
            w_quick_res.status = pes_pkg::ST_FULL;
        end else if ((i_q_cmd.kind == pes_pkg::K_EMIT) && (r_count == '0)) begin
            w_quick_res.status = pes_pkg::ST_EMPTY;
        end
    end

    // table write port: add in idle, time update after a scan
    always_comb begin
        if (r_state == S_UPD) begin
            w_wr_en             = 1'b1;
            w_wr_addr           = r_best_idx;
            w_wr_data.id        = r_best.id;
            w_wr_data.period    = r_best.period;
            w_wr_data.next_time = w_nt;
        end else begin
            w_wr_en             = o_q_pop && (i_q_cmd.kind == pes_pkg::K_ADD) && !w_full;
            w_wr_addr           = r_count[AW-1:0];
            w_wr_data.id        = i_q_cmd.source_id;
            w_wr_data.period    = i_q_cmd.period;
            w_wr_data.next_time = {16'b0, i_q_cmd.period};
        end
    end

    assign w_rd_en = (r_state == S_SCAN) && r_issue;

    pes_ram #(
        .WIDTH (pes_pkg::ENTRY_W),
        .DEPTH (MAX_SOURCES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_raw)
    );

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_issue    <= 1'b0;
            r_rd_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= i_q_valid && w_quick;
                    if (i_q_valid) begin
                        r_result <= w_quick_res;
                        case (i_q_cmd.kind)
                            pes_pkg::K_CLEAR: begin
                                r_count <= '0;
                            end
                            pes_pkg::K_ADD: begin
                                if (!w_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            pes_pkg::K_EMIT: begin
                                if (r_count != '0) begin
                                    r_addr  <= '0;
                                    r_issue <= 1'b1;
                                    r_first <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_strobe <= 1'b0;
                    // issue one read a cycle
                    r_rd_valid <= r_issue;
                    r_rd_idx   <= r_addr;
                    if (r_issue) begin
                        if (r_addr == w_last[AW-1:0]) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    // fold returned entry into the running best
                    if (r_rd_valid) begin
                        r_first <= 1'b0;
                        if (w_take) begin
                            r_best     <= w_rd;
                            r_best_idx <= r_rd_idx;
                        end
                        if (!r_issue) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_result.status     <= pes_pkg::ST_OK;
                    r_result.event_id   <= r_best.id;
                    r_result.event_time <= r_best.next_time;
                    r_result.saturated  <= (w_nt == pes_pkg::TIME_MAX);
                    r_strobe            <= 1'b1;
                    r_rd_valid          <= 1'b0;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // sequencer checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SOURCES))
        else $error("entry count beyond table size");
    a_upd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_strobe && (r_state == S_IDLE)))
        else $error("update did not produce a result");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("command taken while executing");
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan started on empty table");

endmodule

@@ rtl/core/periodic_event_scheduler_unit.sv @@
// top level of the periodic event scheduler: command queue front and table back
//
// A command is taken when start is high and busy is low; a queue of two
// commands sits in front of the executing logic, so busy rises only when
// both slots are taken. Every command gives exactly one result, shown for
// a single cycle with o_strobe high; the receiver cannot stall it. Clear,
// add, unused opcodes and an emit on an empty table put their result on the
// port from the result register once the back end takes them from the queue.
// An emit scans the table through the single read port of the table memory,
// one entry per cycle, then writes the advanced time back and registers its
// result; a following command waits in the queue meanwhile. No clearing pass
// runs after reset: the table is tracked by its fill count.
module periodic_event_scheduler_unit #(
    parameter int MAX_SOURCES = pes_pkg::MAX_SOURCES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pes_pkg::t_in  i_data,
    output logic          o_strobe,
    output pes_pkg::t_out o_result
);

    logic          w_q_valid;
    logic          w_q_pop;
    pes_pkg::t_cmd w_q_cmd;

    // accept and decode
    pes_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_cmd   (w_q_cmd)
    );

    // execute against the table
    pes_back #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_cmd   (w_q_cmd),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule
